// ===== rtl/bis_pkg.sv =====
// shared constants, types and helpers of the bilinear integer upscaler
`timescale 1ns / 1ps
package bis_pkg;

  localparam int unsigned MaxWidth  = 128;
  localparam int unsigned MaxHeight = 128;

  localparam int unsigned XW       = $clog2(MaxWidth);
  localparam int unsigned YW       = $clog2(MaxHeight);
  localparam int unsigned AddrW    = $clog2(MaxWidth * MaxHeight);
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned PixW     = ChanW * NumChan;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned SizeW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivW     = 16;
  localparam int unsigned DivisorW = 8;
  localparam int unsigned WeightW  = 8;
  localparam int unsigned NumTaps  = 4;

  localparam logic [ScaleW-1:0] ScaleReset  = ScaleW'(3);
  localparam logic [SizeW-1:0]  WidthReset  = SizeW'(128);
  localparam logic [SizeW-1:0]  HeightReset = SizeW'(128);

  typedef enum logic [CfgIdxW-1:0] {
    CfgScale  = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_idx_e;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [PixW-1:0]  pix_t;

  function automatic addr_t pix_addr(int unsigned y, int unsigned x);
    return AddrW'(y * MaxWidth + x);
  endfunction

  // last valid index for a programmed size: zero acts as one, large saturates
  function automatic int unsigned size_last(int unsigned v, int unsigned maxv);
    int unsigned r;
    if (v == 0) begin
      r = 0;
    end else if (v > maxv) begin
      r = maxv - 1;
    end else begin
      r = v - 1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/bis_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bis_pkg::DivW-1:0]      dividend_i,
  input  logic [bis_pkg::DivisorW-1:0]  divisor_i,
  output logic [bis_pkg::DivW-1:0]      quot_o,
  output logic [bis_pkg::DivisorW-1:0]  rem_o,
  output logic                          done_o
);
  import bis_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q;
  logic [DivW-1:0]     quot_q, quot_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] div_q;
  logic [DivisorW:0]   trial;

  always_comb begin
    trial  = {rem_q, quot_q[DivW-1]};
    quot_d = {quot_q[DivW-2:0], 1'b0};
    rem_d  = trial[DivisorW-1:0];
    if (trial >= {1'b0, div_q}) begin
      rem_d     = DivisorW'(trial - {1'b0, div_q});
      quot_d[0] = 1'b1;
    end
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CntW'(DivW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !start_i && (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== rtl/bis_store.sv =====
// single-port frame store with registered read data
`timescale 1ns / 1ps
module bis_store (
  input  logic           clk_i,
  input  logic           we_i,
  input  bis_pkg::addr_t addr_i,
  input  bis_pkg::pix_t  wdata_i,
  output bis_pkg::pix_t  rdata_o
);
  import bis_pkg::*;

  pix_t mem [MaxWidth * MaxHeight];
  pix_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bilinear_integer_upscaler.sv =====
// top level of the bilinear integer upscaler
//
// usage: an item is taken when start_i is high and busy_o is low.
// action_i low stores red/green/blue at source (row_i, col_i); stores
// outside the frame store are dropped and give no result.
// action_i high computes the output pixel (row_i, col_i) of the image
// enlarged by scale_factor; busy_o stays high until the result appears.
// a compute item goes through the coordinate divide by N, the weights, the
// four neighbour reads through the single frame store port, a launch step
// and the divide by N*N. the result shows on red_out_o/green_out_o/
// blue_out_o for one cycle with valid_o; the receiver cannot stall, so
// nothing is held back. configuration goes over cfg_valid_i/cfg_ready_o
// with cfg_index_i and cfg_data_i; the user must write it only while
// idle, the block itself does not enforce this. reset restores N = 3 and
// a 128 x 128 source size; the frame store content is undefined until
// written.
`timescale 1ns / 1ps
module bilinear_integer_upscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic [bis_pkg::CoordW-1:0]    row_i,
  input  logic [bis_pkg::CoordW-1:0]    col_i,
  input  logic [bis_pkg::ChanW-1:0]     red_in_i,
  input  logic [bis_pkg::ChanW-1:0]     green_in_i,
  input  logic [bis_pkg::ChanW-1:0]     blue_in_i,
  output logic                          valid_o,
  output logic [bis_pkg::ChanW-1:0]     red_out_o,
  output logic [bis_pkg::ChanW-1:0]     green_out_o,
  output logic [bis_pkg::ChanW-1:0]     blue_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bis_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bis_pkg::SizeW-1:0]     cfg_data_i
);
  import bis_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDivCoord,
    StPrep,
    StFetch,
    StSum,
    StDivPix
  } state_e;

  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       valid_q;

  logic [ScaleW-1:0] scale_q;
  logic [SizeW-1:0]  width_q, height_q;
  logic [ScaleW-1:0] n;
  logic [XW-1:0]     x_last;
  logic [YW-1:0]     y_last;

  logic accept, store_we, compute_go;

  logic [DivW-1:0]     div_dividend [NumChan];
  logic [DivW-1:0]     div_quot [NumChan];
  logic [DivisorW-1:0] div_rem [NumChan];
  logic [NumChan-1:0]  div_done;
  logic [DivisorW-1:0] div_divisor;
  logic                div_start;

  logic [YW-1:0]     sy_c, sy_q, sy1;
  logic [XW-1:0]     sx_c, sx_q, sx1;
  logic [ScaleW-1:0] fy_c, fy_q, fx_c, fx_q;
  logic [ScaleW-1:0] wx_lo, wy_lo;
  logic [WeightW-1:0] w_q [NumTaps];
  logic [DivisorW-1:0] nsq_q;
  logic [DivW-1:0]   acc_q [NumChan];

  logic [1:0]  tap, wsel;
  logic [YW-1:0] ty;
  logic [XW-1:0] tx;
  addr_t mem_addr;
  pix_t  mem_rdata;
  logic [ChanW-1:0] out_q [NumChan];

  assign n      = (scale_q == '0) ? ScaleW'(1) : scale_q;
  assign x_last = XW'(size_last(32'(width_q), MaxWidth));
  assign y_last = YW'(size_last(32'(height_q), MaxHeight));

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign store_we    = accept && !action_i && (32'(row_i) < MaxHeight)
                       && (32'(col_i) < MaxWidth);
  assign compute_go  = accept && action_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgScale:  scale_q  <= cfg_data_i[ScaleW-1:0];
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared dividers: coordinates first, then the weighted sums
  assign div_start   = compute_go || (state_q == StSum);
  assign div_divisor = (state_q == StIdle) ? DivisorW'(n) : nsq_q;

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      if (state_q == StIdle) begin
        div_dividend[k] = (k == 1) ? DivW'(col_i) : DivW'(row_i);
      end else begin
        div_dividend[k] = acc_q[k];
      end
    end
  end

  for (genvar k = 0; k < NumChan; k++) begin : g_div
    bis_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (div_dividend[k]),
      .divisor_i  (div_divisor),
      .quot_o     (div_quot[k]),
      .rem_o      (div_rem[k]),
      .done_o     (div_done[k])
    );
  end

  // coordinates beyond the enlarged image clamp to the edge
  always_comb begin
    if (32'(div_quot[0]) > 32'(y_last)) begin
      sy_c = y_last;
      fy_c = '0;
    end else begin
      sy_c = YW'(div_quot[0]);
      fy_c = div_rem[0][ScaleW-1:0];
    end
    if (32'(div_quot[1]) > 32'(x_last)) begin
      sx_c = x_last;
      fx_c = '0;
    end else begin
      sx_c = XW'(div_quot[1]);
      fx_c = div_rem[1][ScaleW-1:0];
    end
  end

  assign sy1   = (sy_q == y_last) ? sy_q : sy_q + YW'(1);
  assign sx1   = (sx_q == x_last) ? sx_q : sx_q + XW'(1);
  assign wx_lo = n - fx_q;
  assign wy_lo = n - fy_q;

  // neighbour order: a, b, c, d
  assign tap  = cnt_q[1:0];
  assign wsel = 2'(cnt_q - 3'd1);
  assign ty   = tap[1] ? sy1 : sy_q;
  assign tx   = tap[0] ? sx1 : sx_q;

  assign mem_addr = (state_q == StFetch) ? pix_addr(32'(ty), 32'(tx))
                                         : pix_addr(32'(row_i), 32'(col_i));

  bis_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (mem_addr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (compute_go) state_d = StDivCoord;
      end
      StDivCoord: begin
        if (div_done[0]) state_d = StPrep;
      end
      StPrep: begin
        state_d = StFetch;
        cnt_d   = '0;
      end
      StFetch: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(NumTaps)) state_d = StSum;
      end
      StSum: begin
        state_d = StDivPix;
      end
      StDivPix: begin
        if (div_done[0]) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == StDivPix) && div_done[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDivCoord && div_done[0]) begin
      sy_q <= sy_c;
      sx_q <= sx_c;
      fy_q <= fy_c;
      fx_q <= fx_c;
    end
    if (state_q == StPrep) begin
      w_q[0] <= WeightW'(WeightW'(wx_lo) * WeightW'(wy_lo));
      w_q[1] <= WeightW'(WeightW'(fx_q) * WeightW'(wy_lo));
      w_q[2] <= WeightW'(WeightW'(fy_q) * WeightW'(wx_lo));
      w_q[3] <= WeightW'(WeightW'(fx_q) * WeightW'(fy_q));
      nsq_q  <= DivisorW'(DivisorW'(n) * DivisorW'(n));
      for (int k = 0; k < NumChan; k++) begin
        acc_q[k] <= '0;
      end
    end
    if (state_q == StFetch && cnt_q != '0) begin
      for (int k = 0; k < NumChan; k++) begin
        acc_q[k] <= acc_q[k] + DivW'(
          DivW'(mem_rdata[(NumChan-1-k)*ChanW +: ChanW]) * DivW'(w_q[wsel]));
      end
    end
    if (state_q == StDivPix && div_done[0]) begin
      for (int k = 0; k < NumChan; k++) begin
        out_q[k] <= div_quot[k][ChanW-1:0];
      end
    end
  end

  assign valid_o     = valid_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

endmodule
